>>> sv/dced_pkg.sv
// ----------------------------------------------------------------------------
// dced_pkg
// Shared types and constants for the daisy-chain encoder deframer.
// ----------------------------------------------------------------------------
package dced_pkg;

  localparam int unsigned MAX_SENSORS = 64;
  localparam int unsigned FRAME_BITS  = 19;
  localparam int unsigned ACC_BITS    = FRAME_BITS - 1;
  localparam int unsigned PROD_BITS   = 28;

  localparam logic [4:0]  STATUS_OK   = 5'b10000;
  localparam int unsigned ANGLE_SCALE = 36000;
  localparam int unsigned ANGLE_DIV   = 4095;
  localparam int unsigned ROUND_BIAS  = ANGLE_DIV / 2;

  typedef struct packed {
    logic [5:0]  index;
    logic [11:0] raw;
    logic [4:0]  status;
    logic        last;
  } frame_t;

endpackage

>>> sv/daisy_chain_encoder_deframer_top.sv
// ----------------------------------------------------------------------------
// daisy_chain_encoder_deframer_top
// Deframes a serial read from a chain of angle encoders into per-sensor items.
// ----------------------------------------------------------------------------
// Takes one byte per clock, MSB first, with tuser[0] marking the first byte
// of a read. After the one leading bit, every 19 bits form a sensor frame and
// give one output item (raw angle, angle in 0.01 deg, status, good flag, and
// tlast on the last sensor). From input to output item a byte passes an
// input register, the bit accumulator/frame register, and the result
// register after the divide-by-4095 scaling. Sustained rate is one byte per
// cycle; a stall on the output side stalls the whole pipeline. sensor_count
// (1..64, 0 reads as 1, above 64 reads as 64) is to be written through the cfg
// port only while no read is in flight; the block does not enforce this.
module daisy_chain_encoder_deframer_top import dced_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config: sensor_count
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] serial_byte
  input  logic [0:0]  s_axis_tuser,   // [0] read_start
  // output items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [5:0] sensor_index, [17:6] raw_angle,
                                      // [33:18] angle_centidegrees,
                                      // [38:34] status_bits, [39] zero
  output logic [0:0]  m_axis_tuser,   // [0] status_good
  output logic        m_axis_tlast    // last_sensor
);

  logic [6:0]           sensor_count_q;
  logic [6:0]           count_eff;

  logic                 en;
  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 in_start_q;

  logic                 f_valid;
  frame_t               f;
  logic [PROD_BITS-1:0] prod;
  logic [15:0]          centi;

  logic                 m_valid_q;
  frame_t               m_frame_q;
  logic [15:0]          m_centi_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_count_q <= 7'd1;
    end else if (cfg_valid_i) begin
      sensor_count_q <= cfg_data_i;
    end
  end

  always_comb begin
    count_eff = sensor_count_q;
    if (sensor_count_q == 7'd0) begin
      count_eff = 7'd1;
    end else if (sensor_count_q > 7'(MAX_SENSORS)) begin
      count_eff = 7'(MAX_SENSORS);
    end
  end

  // whole pipeline advances unless a result is waiting and not accepted
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser[0];
    end
  end

  dced_deframer u_deframer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_valid_q),
    .byte_i        (in_byte_q),
    .start_i       (in_start_q),
    .count_i       (count_eff),
    .frame_valid_o (f_valid),
    .frame_o       (f),
    .prod_o        (prod)
  );

  dced_scale u_scale (
    .prod_i  (prod),
    .centi_o (centi)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= f_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && f_valid) begin
      m_frame_q <= f;
      m_centi_q <= centi;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = {1'b0, m_frame_q.status, m_centi_q, m_frame_q.raw, m_frame_q.index};
  assign m_axis_tuser[0] = (m_frame_q.status == STATUS_OK);
  assign m_axis_tlast    = m_frame_q.last;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while result stalled");

  a_centi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:18] <= 16'(ANGLE_SCALE))
    else $error("angle out of range");

  a_centi_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17:6] == 12'd0 |-> m_axis_tdata[33:18] == 16'd0)
    else $error("zero raw angle scaled to nonzero");

  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_valid_q, 2))
    else $error("result without input byte");
`endif

endmodule

>>> sv/dced_deframer.sv
// ----------------------------------------------------------------------------
// dced_deframer
// Bit accumulator and frame cutter: takes a byte each enabled cycle, emits at
// most one 19-bit sensor frame, with the scaled angle product, per byte.
// ----------------------------------------------------------------------------
module dced_deframer import dced_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [7:0]           byte_i,
  input  logic                 start_i,
  input  logic [6:0]           count_i,
  output logic                 frame_valid_o,
  output frame_t               frame_o,
  output logic [PROD_BITS-1:0] prod_o
);

  logic [ACC_BITS-1:0]  acc_q, acc_d;
  logic [4:0]           held_q, held_d;
  logic [6:0]           ns_q, ns_d;
  logic                 lead_q, lead_d;

  logic                 f_valid_q;
  frame_t               f_q, f_d;
  logic [PROD_BITS-1:0] prod_q, prod_d;

  logic [ACC_BITS-1:0]  acc0;
  logic [4:0]           held0;
  logic [6:0]           ns0;
  logic [6:0]           ns_inc;
  logic                 lead0;
  logic                 active;
  logic                 done;
  logic [25:0]          comb;
  logic [25:0]          comb_sh;
  logic [4:0]           total;
  logic [2:0]           sh;
  logic [6:0]           rem;

  always_comb begin
    // read start clears the state before the byte is used
    acc0   = start_i ? '0 : acc_q;
    held0  = start_i ? '0 : held_q;
    ns0    = start_i ? '0 : ns_q;
    lead0  = start_i ? 1'b1 : lead_q;
    ns_inc = ns0 + 7'd1;

    active = ns0 < count_i;
    // with the lead bit pending only the low seven bits of the byte count
    comb   = lead0 ? {1'b0, acc0, byte_i[6:0]} : {acc0, byte_i};
    total  = held0 + (lead0 ? 5'd7 : 5'd8);
    done   = active && (total >= 5'(FRAME_BITS));
    sh     = 3'(total - 5'(FRAME_BITS));
    comb_sh = comb >> sh;
    rem    = comb[6:0] & ((7'd1 << sh) - 7'd1);

    acc_d  = acc0;
    held_d = held0;
    ns_d   = ns0;
    lead_d = lead0;
    if (active && !done) begin
      acc_d  = comb[ACC_BITS-1:0];
      held_d = total;
      lead_d = 1'b0;
    end else if (done) begin
      lead_d = 1'b0;
      ns_d   = ns_inc;
      if (ns_inc < count_i) begin
        acc_d  = ACC_BITS'(rem);
        held_d = {2'b00, sh};
      end else begin
        // chain complete: rest of the read is dropped
        acc_d  = '0;
        held_d = '0;
      end
    end

    f_d.index  = ns0[5:0];
    f_d.raw    = comb_sh[18:7];
    f_d.status = comb_sh[6:2];
    f_d.last   = (ns_inc == count_i);
    prod_d     = PROD_BITS'(f_d.raw) * PROD_BITS'(ANGLE_SCALE) + PROD_BITS'(ROUND_BIAS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      held_q    <= '0;
      ns_q      <= '0;
      lead_q    <= 1'b1;
      f_valid_q <= 1'b0;
    end else if (en_i) begin
      f_valid_q <= valid_i && done;
      if (valid_i) begin
        acc_q  <= acc_d;
        held_q <= held_d;
        ns_q   <= ns_d;
        lead_q <= lead_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i && done) begin
      f_q    <= f_d;
      prod_q <= prod_d;
    end
  end

  assign frame_valid_o = f_valid_q;
  assign frame_o       = f_q;
  assign prod_o        = prod_q;

endmodule

>>> sv/dced_scale.sv
// ----------------------------------------------------------------------------
// dced_scale
// Divides the rounded angle product by 4095 with a reciprocal series and a
// single upward correction; no divider.
// ----------------------------------------------------------------------------
module dced_scale import dced_pkg::*; (
  input  logic [PROD_BITS-1:0] prod_i,
  output logic [15:0]          centi_o
);

  logic [PROD_BITS:0] t;
  logic [16:0]        est;
  logic [PROD_BITS:0] r;

  always_comb begin
    // x/4095 = x/4096 * (1 + 2^-12 + 2^-24 + ...); estimate is never high
    t   = {1'b0, prod_i} + (PROD_BITS+1)'(prod_i >> 12) + (PROD_BITS+1)'(prod_i >> 24);
    est = 17'(t >> 12);
    r   = {1'b0, prod_i} - ((PROD_BITS+1)'(est) << 12) + (PROD_BITS+1)'(est);
    centi_o = 16'(est + ((r >= (PROD_BITS+1)'(ANGLE_DIV)) ? 17'd1 : 17'd0));
  end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the daisy-chain encoder deframer. Feeds serial reads built from
// random sensor frames (plus truncated reads and line noise) under several
// chain lengths, predicts each sensor item, and checks the output stream.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dced_pkg::*;

  typedef struct packed {
    logic [5:0]  idx;
    logic [11:0] raw;
    logic [15:0] centi;
    logic [4:0]  status;
    logic        good;
    logic        last;
  } sensor_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] serial_byte
  logic [0:0]  s_axis_tuser = '0;   // [0] read_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [5:0] index, [17:6] raw, [33:18] centi,
                                    // [38:34] status, [39] zero
  logic [0:0]  m_axis_tuser;        // [0] status_good
  logic        m_axis_tlast;        // last_sensor

  daisy_chain_encoder_deframer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Deframer prediction state, reset values
  logic [18:0]  frame_sr = '0;
  int unsigned  frame_fill = 0;
  int unsigned  next_sensor = 0;
  bit           lead_pending = 1'b1;
  logic [6:0]   sensor_count = 7'd1;

  sensor_rec_t  sensor_due_q[$];
  logic [8:0]   byte_feed_q[$];     // {read_start, serial_byte}
  logic [18:0]  frame_plan[$];
  int unsigned  bytes_planned = 0;
  int unsigned  mismatches = 0;
  bit           calm = 1'b0;        // no idling on either side

  task automatic deframe_byte(input logic [7:0] data, input logic start);
    int unsigned chain_len;
    sensor_rec_t rec;
    if (start) begin
      frame_sr     = '0;
      frame_fill   = 0;
      next_sensor  = 0;
      lead_pending = 1'b1;
    end
    chain_len = (sensor_count == 0) ? 1 :
                (sensor_count > MAX_SENSORS) ? MAX_SENSORS : sensor_count;
    for (int i = 7; i >= 0; i--) begin
      if (next_sensor < chain_len) begin
        if (lead_pending) begin
          lead_pending = 1'b0;
        end else begin
          frame_sr = {frame_sr[17:0], data[i]};
          frame_fill++;
          if (frame_fill == FRAME_BITS) begin
            rec.idx    = 6'(next_sensor);
            rec.raw    = frame_sr[18:7];
            rec.centi  = 16'((rec.raw * ANGLE_SCALE + ROUND_BIAS) / ANGLE_DIV);
            rec.status = frame_sr[6:2];
            rec.good   = (frame_sr[6:2] == STATUS_OK);
            rec.last   = (next_sensor + 1 == chain_len);
            sensor_due_q.push_back(rec);
            frame_fill = 0;
            next_sensor++;
          end
        end
      end
    end
  endtask

  task automatic check_field(input string field, input logic [5:0] idx,
                             input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s, sensor %0d: expected %0h, got %0h", field, idx, want, got);
    end
  endtask

  // ---------------- input side ----------------
  bit byte_taken = 1'b0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      deframe_byte(s_axis_tdata, s_axis_tuser[0]);
      byte_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    logic [8:0] nxt;
    if (rst_ni && !(s_axis_tvalid && !byte_taken)) begin
      byte_taken = 1'b0;
      if (gap_left > 0 && !calm) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (byte_feed_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 2);
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = byte_feed_q.pop_front();
        s_axis_tdata  <= nxt[7:0];
        s_axis_tuser  <= nxt[8];
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // ---------------- output side ----------------
  int stall_left = 0;

  always @(posedge clk_i) begin
    sensor_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sensor_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: tdata %h tuser %b tlast %b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = sensor_due_q.pop_front();
        check_field("sensor_index", want.idx, 16'(want.idx), 16'(m_axis_tdata[5:0]));
        check_field("raw_angle", want.idx, 16'(want.raw), 16'(m_axis_tdata[17:6]));
        check_field("angle_centidegrees", want.idx, want.centi, m_axis_tdata[33:18]);
        check_field("status_bits", want.idx, 16'(want.status), 16'(m_axis_tdata[38:34]));
        check_field("pad", want.idx, 16'd0, 16'(m_axis_tdata[39]));
        check_field("status_good", want.idx, 16'(want.good), 16'(m_axis_tuser[0]));
        check_field("last_sensor", want.idx, 16'(want.last), 16'(m_axis_tlast));
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------- stimulus ----------------
  task automatic write_sensor_count(input logic [6:0] value);
    @(negedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sensor_count = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drains input and output, then covers reads that end without a result.
  task automatic wait_idle();
    int guard = 0;
    do @(posedge clk_i);
    while ((byte_feed_q.size() != 0 || s_axis_tvalid || sensor_due_q.size() != 0)
           && guard++ < 100000);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [18:0] pick_frame();
    logic [11:0] raw;
    logic [4:0]  st;
    case ($urandom_range(0, 7))
      0:       raw = '0;
      1:       raw = '1;
      default: raw = 12'($urandom);
    endcase
    st = ($urandom_range(0, 4) < 3) ? STATUS_OK : 5'($urandom);
    return {raw, st, 2'($urandom)};
  endfunction

  // Serializes lead bit + frame_plan MSB first; cut drops bits off the end,
  // tail appends bytes the block should ignore.
  task automatic add_read(input bit start, input int unsigned cut, input int unsigned tail);
    bit          stream[$];
    logic [7:0]  b;
    int unsigned k;
    bit          first;
    stream.push_back(1'($urandom));
    foreach (frame_plan[f])
      for (int i = 18; i >= 0; i--) stream.push_back(frame_plan[f][i]);
    frame_plan.delete();
    repeat (cut) if (stream.size() > 1) void'(stream.pop_back());
    k = 0;
    first = start;
    while (k < stream.size()) begin
      b = 8'($urandom);
      for (int i = 7; i >= 0; i--) begin
        if (k < stream.size()) begin
          b[i] = stream[k];
          k++;
        end
      end
      byte_feed_q.push_back({first, b});
      first = 1'b0;
      bytes_planned++;
    end
    repeat (tail) byte_feed_q.push_back({1'b0, 8'($urandom)});
  endtask

  task automatic add_noise(input int unsigned n, input int unsigned start_odds);
    repeat (n) begin
      byte_feed_q.push_back({1'($urandom_range(0, start_odds - 1) == 0), 8'($urandom)});
      bytes_planned++;
    end
  endtask

  initial begin
    logic [6:0]  count;
    int unsigned chain_len;
    int unsigned phase;
    int unsigned pick;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Bytes before any read start, chain length still at its reset value
    frame_plan.push_back({12'hFFF, STATUS_OK, 2'b00});
    add_read(1'b0, 0, 1);
    frame_plan.push_back({12'h000, 5'h1F, 2'b11});
    add_read(1'b1, 0, 1);
    // read start arriving in the middle of a frame
    frame_plan.push_back(pick_frame());
    add_read(1'b1, 10, 0);
    frame_plan.push_back({12'h800, 5'h00, 2'b01});
    add_read(1'b1, 0, 0);
    wait_idle();

    write_sensor_count(7'd2);
    frame_plan.push_back({12'hFFF, STATUS_OK, 2'b00});
    frame_plan.push_back({12'h800, 5'b01111, 2'b10});
    add_read(1'b1, 0, 2);
    byte_feed_q.push_back({1'b1, 8'h00});
    byte_feed_q.push_back({1'b0, 8'hFF});
    byte_feed_q.push_back({1'b0, 8'hFF});
    byte_feed_q.push_back({1'b0, 8'h00});
    bytes_planned += 4;

    phase = 0;
    while (bytes_planned < 1000) begin
      wait_idle();
      if (bytes_planned > 850) calm = 1'b1;
      case (phase)
        0: count = 7'd0;
        1: count = 7'd64;
        2: count = 7'd127;
        3: count = 7'd1;
        default: begin
          pick = $urandom_range(0, 19);
          if (pick < 15)      count = 7'($urandom_range(1, 6));
          else if (pick < 19) count = 7'($urandom_range(7, 24));
          else                count = 7'($urandom_range(65, 127));
        end
      endcase
      write_sensor_count(count);
      chain_len = (count == 0) ? 1 : (count > MAX_SENSORS) ? MAX_SENSORS : count;

      // carry on with a read left open by the previous setting
      if (phase > 0 && $urandom_range(0, 3) == 0)
        add_noise($urandom_range(1, 4), 1000);

      repeat ((chain_len > 24) ? 1 : $urandom_range(1, 3)) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          repeat (chain_len) frame_plan.push_back(pick_frame());
          add_read(1'b1, 0, $urandom_range(0, 2));
        end else if (pick < 88) begin
          repeat (chain_len) frame_plan.push_back(pick_frame());
          add_read(1'b1, $urandom_range(1, 40), 0);
        end else begin
          add_noise($urandom_range(1, 6), 4);
        end
      end
      // sometimes leave the read open across the next setting change
      if ($urandom_range(0, 2) == 0) begin
        repeat (chain_len) frame_plan.push_back(pick_frame());
        add_read(1'b1, $urandom_range(1, 30), 0);
      end
      phase++;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    mismatches += sensor_due_q.size();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
